/* design/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros for the log2 pipeline checkers.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// prop must hold at every clock edge outside reset
`define CHK_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error(msg);

// cond must never be true at a clock edge outside reset
`define CHK_NEVER(label, clk, rst, cond, msg) \
   `CHK_ASSERT(label, clk, rst, !(cond), msg)

`endif

/* design/log2pa_pkg.sv */
// ----------------------------------------------------------------------------
// log2pa_pkg
// Constants shared by the log2 approximation pipeline, its channels and
// its checker.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package log2pa_pkg;

   localparam int VALUE_W    = 32;
   localparam int OUT_W      = 33;
   localparam int EXPO_W     = 9;
   localparam int NUM_COEF   = 9;
   // decode stage, then a multiply stage and a round/add stage per coefficient
   localparam int PIPE_DEPTH = 1 + 2 * NUM_COEF;

   localparam logic [31:0] MIN_NORMAL = 32'h0080_0000;
   localparam logic [31:0] RENORM_OFS = 32'h3f2a_aaab;
   localparam logic [31:0] FLOAT_ONE  = 32'h3f80_0000;

   // log2(e) in Q.60
   localparam logic [63:0] L2E_Q60 = 64'h1715_4765_2B82_FE17;

   // floor(log2(e) / k) in Q.60, k = 1..9
   localparam logic [63:0] L2E_DIV [1:NUM_COEF] = '{
      L2E_Q60 / 64'd1, L2E_Q60 / 64'd2, L2E_Q60 / 64'd3,
      L2E_Q60 / 64'd4, L2E_Q60 / 64'd5, L2E_Q60 / 64'd6,
      L2E_Q60 / 64'd7, L2E_Q60 / 64'd8, L2E_Q60 / 64'd9
   };

endpackage

`default_nettype wire

/* design/log2pa_if.sv */
// ----------------------------------------------------------------------------
// log2pa_req_if / log2pa_rsp_if
// Valid/ready channels for operands and results of the log2 pipeline.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface log2pa_req_if;
   logic                              valid;
   logic                              ready;
   logic [log2pa_pkg::VALUE_W-1:0]    value_bits;

   modport source (output valid, output value_bits, input ready);
   modport sink   (input valid, input value_bits, output ready);
   modport mon    (input valid, input value_bits, input ready);
endinterface

interface log2pa_rsp_if;
   logic                              valid;
   logic                              ready;
   logic signed [log2pa_pkg::OUT_W-1:0] log_value;

   modport source (output valid, output log_value, input ready);
   modport sink   (input valid, input log_value, output ready);
   modport mon    (input valid, input log_value, input ready);
endinterface

`default_nettype wire

/* design/log2_polynomial_approx_top.sv */
// ----------------------------------------------------------------------------
// log2_polynomial_approx_top
// Fixed-point base-2 logarithm of a single-precision float bit pattern.
// ----------------------------------------------------------------------------
// Takes one operand per cycle unless all stages hold an item and the result
// side is stalled, and returns one result per operand, in order. The stages
// form the Horner chain: a decode stage, then for each of the nine
// coefficients one stage holding the product acc*x and one stage doing
// the rounding and the coefficient add. Every stage carries its own valid bit
// and empty stages close up under a stall, so the operand side keeps
// accepting until all 19 stages hold an item. Negative operands, zero and
// denormals read as the smallest normal; infinity and NaN are treated as
// large normals. The result is signed with FRAC_BITS fraction bits, wrapped
// to 33 bits.
`timescale 1ns / 1ps
`default_nettype none

module log2_polynomial_approx_top #(
   parameter int FRAC_BITS = 24
) (
   input  wire logic      clock,
   input  wire logic      reset,
   log2pa_req_if.sink     req_ch,
   log2pa_rsp_if.source   rsp_ch
);

   localparam int F     = FRAC_BITS;
   localparam int XW    = F + 1;                 // x in [-1/3, 1/3)
   localparam int AW    = F + 2;                 // Horner accumulator
   localparam int PW    = XW + AW;               // full product
   localparam int EW    = log2pa_pkg::EXPO_W;
   localparam int RW    = (F + EW + 1 > log2pa_pkg::OUT_W) ? F + EW + 1 : log2pa_pkg::OUT_W;
   localparam int NC    = log2pa_pkg::NUM_COEF;
   localparam int S     = log2pa_pkg::PIPE_DEPTH;

   localparam logic [PW:0] HALF = (PW + 1)'(1) << (F - 1);

   localparam logic [63:0] C9_MAG =
      (log2pa_pkg::L2E_DIV[NC] + (64'd1 << (59 - F))) >> (60 - F);
   localparam logic signed [AW-1:0] C9 = $signed(C9_MAG[AW-1:0]);

   // stage valid bits and load enables
   logic             valid_ff [0:S-1];
   logic             ld       [0:S];

   logic signed [XW-1:0] x_ff    [0:S-3];
   logic signed [EW-1:0] e_ff    [0:S-2];
   logic signed [PW-1:0] prod_ff [0:NC-1];
   logic signed [AW-1:0] acc_ff  [1:NC-1];
   logic signed [log2pa_pkg::OUT_W-1:0] res_ff;

   // ---------------- handshake ----------------
   assign ld[S] = rsp_ch.ready;

   genvar gi;
   generate
      for (gi = 0; gi < S; gi++) begin : g_ld
         assign ld[gi] = !valid_ff[gi] || ld[gi + 1];
      end
   endgenerate

   assign req_ch.ready = ld[0];
   assign rsp_ch.valid = valid_ff[S-1];
   assign rsp_ch.log_value = res_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int j = 0; j < S; j++) begin
            valid_ff[j] <= 1'b0;
         end
      end else begin
         if (ld[0]) begin
            valid_ff[0] <= req_ch.valid;
         end
         for (int j = 1; j < S; j++) begin
            if (ld[j]) begin
               valid_ff[j] <= valid_ff[j-1];
            end
         end
      end
   end

   // ---------------- decode ----------------
   logic [31:0]          clamp_bits;
   logic [31:0]          diff;
   logic [31:0]          renorm;
   logic [22:0]          mant;
   logic signed [24:0]   x24;
   logic signed [XW-1:0] x_in;
   logic signed [EW-1:0] e_in;

   always_comb begin
      if (req_ch.value_bits[31] || req_ch.value_bits[30:23] == 8'd0) begin
         clamp_bits = log2pa_pkg::MIN_NORMAL;
      end else begin
         clamp_bits = req_ch.value_bits;
      end
      diff   = clamp_bits - log2pa_pkg::RENORM_OFS;
      e_in   = $signed(diff[31:23]);
      renorm = {9'd0, diff[22:0]} + log2pa_pkg::RENORM_OFS;
      mant   = renorm[22:0];
      // below 1.0 the float has exponent 2^-1, so x = m - 1 = mant - 2^23
      if (renorm < log2pa_pkg::FLOAT_ONE) begin
         x24 = $signed({2'b00, mant}) - 25'sh080_0000;
      end else begin
         x24 = $signed({1'b0, mant, 1'b0});
      end
   end

   generate
      if (F >= 24) begin : g_xwide
         assign x_in = XW'(x24) <<< (F - 24);
      end else begin : g_xnarrow
         localparam logic signed [25:0] XHALF = 26'(1) << (23 - F);
         logic signed [25:0] x_sum;
         logic signed [25:0] x_sh;
         assign x_sum = $signed({x24[24], x24}) + XHALF;
         assign x_sh  = x_sum >>> (24 - F);
         assign x_in  = x_sh[XW-1:0];
      end
   endgenerate

   always_ff @(posedge clock) begin
      if (ld[0]) begin
         x_ff[0] <= x_in;
         e_ff[0] <= e_in;
      end
      for (int j = 1; j < S - 1; j++) begin
         if (ld[j]) begin
            e_ff[j] <= e_ff[j-1];
         end
      end
      // x is last needed by the final multiply stage
      for (int j = 1; j < S - 2; j++) begin
         if (ld[j]) begin
            x_ff[j] <= x_ff[j-1];
         end
      end
   end

   // ---------------- Horner chain ----------------
   generate
      for (gi = 0; gi < NC; gi++) begin : g_step
         logic signed [AW-1:0] acc_src;
         logic signed [PW:0]   rnd_sum;
         logic signed [PW:0]   rnd_sh;
         logic signed [AW-1:0] rnd;

         if (gi == 0) begin : g_first
            assign acc_src = C9;
         end else begin : g_next
            assign acc_src = acc_ff[gi];
         end

         // multiply stage
         always_ff @(posedge clock) begin
            if (ld[2 * gi + 1]) begin
               prod_ff[gi] <= acc_src * x_ff[2 * gi];
            end
         end

         // round to nearest, ties toward plus infinity
         assign rnd_sum = $signed({prod_ff[gi][PW-1], prod_ff[gi]}) + $signed(HALF);
         assign rnd_sh  = rnd_sum >>> F;
         assign rnd     = rnd_sh[AW-1:0];

         if (gi < NC - 1) begin : g_add
            localparam int K = NC - 1 - gi;
            localparam logic [63:0] CMAG =
               (log2pa_pkg::L2E_DIV[K] + (64'd1 << (59 - F))) >> (60 - F);
            localparam logic signed [AW-1:0] COEF =
               ((K % 2) == 1) ? $signed(CMAG[AW-1:0]) : -$signed(CMAG[AW-1:0]);

            always_ff @(posedge clock) begin
               if (ld[2 * gi + 2]) begin
                  acc_ff[gi + 1] <= COEF + rnd;
               end
            end
         end else begin : g_final
            logic signed [RW-1:0] res_sum;
            assign res_sum = RW'($signed({e_ff[S-2], {F{1'b0}}})) + RW'(rnd);

            always_ff @(posedge clock) begin
               if (ld[S-1]) begin
                  res_ff <= res_sum[log2pa_pkg::OUT_W-1:0];
               end
            end
         end
      end
   endgenerate

endmodule

`default_nettype wire

/* design/log2pa_checker.sv */
// ----------------------------------------------------------------------------
// log2pa_assert
// Port-level checks on the log2 pipeline: result hold under stall and
// occupancy versus the input and output handshakes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module log2pa_assert (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   input  wire logic                          req_ready,
   input  wire logic                          rsp_valid,
   input  wire logic                          rsp_ready,
   input  wire logic [log2pa_pkg::OUT_W-1:0]  rsp_log_value
);

   localparam int CW = $clog2(log2pa_pkg::PIPE_DEPTH + 1);
   localparam logic [CW-1:0] DEPTH = CW'(log2pa_pkg::PIPE_DEPTH);

   logic          req_xfer;
   logic          rsp_xfer;
   logic [CW-1:0] count_ff;
   logic [CW-1:0] count_in;

   assign req_xfer = req_valid && req_ready;
   assign rsp_xfer = rsp_valid && rsp_ready;

   always_comb begin
      count_in = count_ff;
      if (req_xfer && !rsp_xfer) begin
         count_in = count_ff + CW'(1);
      end else if (!req_xfer && rsp_xfer) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   `CHK_ASSERT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_log_value), "result changed under stall")
   `CHK_NEVER(a_rsp_empty, clock, reset, (count_ff == '0) && rsp_valid, "result with nothing in flight")
   `CHK_ASSERT(a_full_stall, clock, reset, !req_ready |-> count_ff == DEPTH, "input stalled while pipeline has a bubble")

endmodule

bind log2_polynomial_approx_top log2pa_assert u_log2pa_assert (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_ch.valid),
   .req_ready     (req_ch.ready),
   .rsp_valid     (rsp_ch.valid),
   .rsp_ready     (rsp_ch.ready),
   .rsp_log_value (rsp_ch.log_value)
);

`default_nettype wire
